// ----- src/gbc_pkg.sv -----
// Shared types, constants and functions for the GOST 28147-89 block cipher.
// No dependencies; used by gbc_round_cell and gost_block_cipher.
package gbc_pkg;

  localparam int unsigned Rounds   = 32;
  localparam int unsigned KeyWords = 8;
  localparam int unsigned RotAmt   = 11;

  typedef logic [31:0] word_t;
  typedef logic [2:0]  key_idx_t;

  // One block in flight between round cells.
  typedef struct packed {
    logic  decrypt;
    word_t n1;
    word_t n2;
  } blk_t;

  localparam logic [0:7][0:15][3:0] SBOX = '{
    '{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
      4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3},
    '{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
      4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
    '{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
      4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
    '{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
      4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
    '{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
      4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
    '{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
      4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
      4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
    '{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
      4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12}
  };

  // Key word used in encryption round r: 0..7 three times, then 7..0.
  function automatic key_idx_t enc_key_index(input int unsigned r);
    key_idx_t low;
    low = key_idx_t'(r % KeyWords);
    return (r < 24) ? low : (3'd7 - low);
  endfunction

  // Round function: add subkey, eight 4-bit S-boxes, rotate left by 11.
  function automatic word_t round_f(input word_t half, input word_t sk);
    word_t sum;
    word_t s;
    sum = half + sk;
    for (int n = 0; n < 8; n++) begin
      s[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
    end
    return {s[31-RotAmt:0], s[31:32-RotAmt]};
  endfunction

endpackage

// ----- src/gbc_round_cell.sv -----
// One Feistel round with its own valid/ready stage register.
// Depends on gbc_pkg.
module gbc_round_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  gbc_pkg::blk_t  up_data,
  input  gbc_pkg::word_t key_enc,
  input  gbc_pkg::word_t key_dec,
  output logic           dn_valid,
  input  logic           dn_ready,
  output gbc_pkg::blk_t  dn_data
);

  logic           valid_r, valid_nxt;
  gbc_pkg::blk_t  data_r, data_nxt;
  gbc_pkg::word_t sk;

  assign up_ready = !valid_r || dn_ready;
  assign sk       = up_data.decrypt ? key_dec : key_enc;

  always_comb begin
    valid_nxt        = up_ready ? up_valid : valid_r;
    data_nxt.decrypt = up_data.decrypt;
    data_nxt.n1      = up_data.n2 ^ gbc_pkg::round_f(up_data.n1, sk);
    data_nxt.n2      = up_data.n1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- src/gost_block_cipher.sv -----
// GOST 28147-89 block cipher, fully unrolled: a chain of 32 round cells.
// Depends on gbc_pkg and gbc_round_cell.
//
//  channel | ports                                  | dir | handshake
//  --------+----------------------------------------+-----+-----------------
//  input   | in_func, in_block_low, in_block_high   | in  | in_valid/in_ready
//  result  | out_result_low, out_result_high        | out | out_valid/out_ready
//  config  | cfg_index, cfg_wdata                   | in  | cfg_we, no wait
//
// One item per cycle while the result side keeps out_ready high; each round cell is a register stage.
// The last cell's register is the output register.
// Each cell holds its item while the next one is full and stalled, so bubbles collapse
// and a stalled output backs up the run of full cells behind it, while empty cells upstream still fill.
// Synchronous reset clears all cell valid bits and the key words to zero.
module gost_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_block_low,
  input  logic [31:0] in_block_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_low,
  output logic [31:0] out_result_high,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned NR = gbc_pkg::Rounds;

  gbc_pkg::word_t key_r [gbc_pkg::KeyWords];

  logic          vld [NR+1];
  logic          rdy [NR+1];
  gbc_pkg::blk_t dat [NR+1];
  logic [NR-1:0] busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gbc_pkg::KeyWords; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  assign vld[0]         = in_valid;
  assign dat[0].decrypt = in_func;
  assign dat[0].n1      = in_block_low;
  assign dat[0].n2      = in_block_high;
  assign in_ready       = rdy[0];
  assign rdy[NR]        = out_ready;

  for (genvar r = 0; r < NR; r++) begin : g_cell
    localparam gbc_pkg::key_idx_t KE = gbc_pkg::enc_key_index(r);
    localparam gbc_pkg::key_idx_t KD = gbc_pkg::enc_key_index(NR - 1 - r);

    gbc_round_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[r]),
      .up_ready (rdy[r]),
      .up_data  (dat[r]),
      .key_enc  (key_r[KE]),
      .key_dec  (key_r[KD]),
      .dn_valid (vld[r+1]),
      .dn_ready (rdy[r+1]),
      .dn_data  (dat[r+1])
    );

    assign busy[r] = vld[r+1];
  end

  // Halves come out swapped.
  assign out_valid       = vld[NR];
  assign out_result_low  = dat[NR].n2;
  assign out_result_high = dat[NR].n1;

  // Input only backs up when every cell holds an item.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> &busy)
    else $error("input stalled with an empty cell in the chain");

  a_enter_first_cell: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> busy[0])
    else $error("accepted item missing from first cell");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && busy == '0)
    else $error("cells not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_low)
      && $stable(out_result_high))
    else $error("stalled result changed");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for gost_block_cipher (GOST 28147-89, 32 rounds).
// Depends on gbc_pkg and the RTL; an internal cipher model predicts each result.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 64;

  // Fixed S-boxes, row n serves nibble n (nibble 0 is the least significant).
  localparam logic [0:7][0:15][3:0] SUBST = {
    {4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
     4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3},
    {4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
     4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
    {4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
     4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
    {4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
     4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
    {4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
     4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
    {4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
     4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
    {4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
     4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
    {4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
     4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12}
  };

  localparam logic FuncEncrypt = 1'b0;
  localparam logic FuncDecrypt = 1'b1;

  typedef struct packed {
    gbc_pkg::word_t low;
    gbc_pkg::word_t high;
  } cipher_block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = FuncEncrypt;
  logic [31:0] in_block_low = '0;
  logic [31:0] in_block_high = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_low;
  logic [31:0] out_result_high;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  gbc_pkg::word_t key_shadow [gbc_pkg::KeyWords];
  cipher_block_t  expected_blocks [$];
  int unsigned    idle_pct = 30;
  int unsigned    cycle_count = 0;
  int unsigned    error_count = 0;
  int unsigned    encrypt_count = 0;
  int unsigned    decrypt_count = 0;
  int unsigned    result_count = 0;
  int unsigned    key_writes = 0;

  gost_block_cipher dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_block_low   (in_block_low),
    .in_block_high  (in_block_high),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_low (out_result_low),
    .out_result_high(out_result_high),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_blocks.size());
      $display("FAIL");
      $finish;
    end
  end

  // 32 Feistel rounds; decryption walks the encryption schedule backwards.
  function automatic cipher_block_t gost_crypt_block(input logic decrypt,
                                                     input gbc_pkg::word_t n1_in,
                                                     input gbc_pkg::word_t n2_in);
    gbc_pkg::word_t n1;
    gbc_pkg::word_t n2;
    gbc_pkg::word_t hold;
    gbc_pkg::word_t sum;
    gbc_pkg::word_t s;
    logic [4:0] sched;
    logic [2:0] ki;
    cipher_block_t res;
    n1 = n1_in;
    n2 = n2_in;
    for (int r = 0; r < 32; r++) begin
      sched = decrypt ? 5'(31 - r) : 5'(r);
      ki = (sched < 5'd24) ? sched[2:0] : 3'd7 - sched[2:0];
      sum = n1 + key_shadow[ki];
      for (int n = 0; n < 8; n++) begin
        s[4*n +: 4] = SUBST[n][sum[4*n +: 4]];
      end
      hold = n1;
      n1 = n2 ^ {s[20:0], s[31:21]};
      n2 = hold;
    end
    res.low = n2;
    res.high = n1;
    return res;
  endfunction

  // Result checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    cipher_block_t exp_blk;
    if (rst_n && out_valid && out_ready) begin
      result_count <= result_count + 1;
      if (expected_blocks.size() == 0) begin
        $error("unexpected result low=%h high=%h", out_result_low, out_result_high);
        error_count = error_count + 1;
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (out_result_low !== exp_blk.low) begin
          $error("result_low: expected %h, got %h", exp_blk.low, out_result_low);
          error_count = error_count + 1;
        end
        if (out_result_high !== exp_blk.high) begin
          $error("result_high: expected %h, got %h", exp_blk.high, out_result_high);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Result-side stalls.
  always @(negedge clk) begin
    out_ready <= (idle_pct == 0) || ($urandom_range(0, 99) >= idle_pct);
  end

  // Sends one item; noise on the payload while valid is low.
  task automatic send_block(input logic decrypt, input gbc_pkg::word_t n1,
                            input gbc_pkg::word_t n2);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      in_func <= 1'($urandom);
      in_block_low <= $urandom;
      in_block_high <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= decrypt;
    in_block_low <= n1;
    in_block_high <= n2;
    do @(posedge clk); while (!in_ready);
    expected_blocks.push_back(gost_crypt_block(decrypt, n1, n2));
    if (decrypt == FuncDecrypt) decrypt_count++;
    else encrypt_count++;
  endtask

  // Every item yields one result, so an empty queue means the pipe is empty.
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_key_word(input gbc_pkg::key_idx_t idx, input gbc_pkg::word_t value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    key_shadow[idx] = value;
    key_writes++;
  endtask

  task automatic load_key(input gbc_pkg::word_t w0, w1, w2, w3, w4, w5, w6, w7);
    gbc_pkg::word_t words [gbc_pkg::KeyWords];
    words = '{w0, w1, w2, w3, w4, w5, w6, w7};
    for (int i = 0; i < gbc_pkg::KeyWords; i++)
      set_key_word(gbc_pkg::key_idx_t'(i), words[i]);
  endtask

  function automatic gbc_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return gbc_pkg::word_t'(1) << $urandom_range(0, 31);
      3:       return ~(gbc_pkg::word_t'(1) << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Cipher and its inverse: the second item takes the first one's predicted result.
  task automatic send_round_trip(input logic first_func, input gbc_pkg::word_t n1,
                                 input gbc_pkg::word_t n2);
    cipher_block_t mid;
    mid = gost_crypt_block(first_func, n1, n2);
    send_block(first_func, n1, n2);
    send_block(~first_func, mid.low, mid.high);
  endtask

  task automatic test_reset_key();
    send_block(FuncEncrypt, '0, '0);
    send_block(FuncDecrypt, '0, '0);
    send_block(FuncEncrypt, '1, '1);
    send_block(FuncDecrypt, '1, '0);
    drain_pipe();
  endtask

  task automatic test_all_ones_key();
    load_key('1, '1, '1, '1, '1, '1, '1, '1);
    send_block(FuncEncrypt, '0, '1);
    send_block(FuncDecrypt, '1, '1);
    send_round_trip(FuncEncrypt, 32'h8000_0001, 32'h7fff_fffe);
    drain_pipe();
  endtask

  // One hot key word at a time exposes the subkey order in both directions.
  task automatic test_key_schedule();
    load_key('0, '0, '0, '0, '0, '0, '0, '0);
    drain_pipe();
    for (int i = 0; i < gbc_pkg::KeyWords; i++) begin
      if (i > 0) set_key_word(gbc_pkg::key_idx_t'(i - 1), '0);
      set_key_word(gbc_pkg::key_idx_t'(i), 32'hffff_ffff);
      send_block((i % 2) ? FuncDecrypt : FuncEncrypt, 32'h0123_4567, 32'h89ab_cdef);
      drain_pipe();
    end
  endtask

  task automatic test_random_blocks();
    int unsigned roll;
    for (int phase = 0; phase < 6; phase++) begin
      drain_pipe();
      if (phase == 1)
        load_key(32'haaaa_aaaa, 32'h5555_5555, '0, '1, 32'h8000_0000, 32'h1, '1, '0);
      else
        load_key(pick_word(), pick_word(), pick_word(), pick_word(),
                 pick_word(), pick_word(), pick_word(), pick_word());
      // one phase runs with no idling on either side
      idle_pct = (phase == 3) ? 0 : 30;
      for (int k = 0; k < 125; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          send_round_trip(1'($urandom), pick_word(), pick_word());
          k++;
        end else begin
          send_block(1'($urandom), pick_word(), pick_word());
        end
      end
    end
    idle_pct = 30;
  endtask

  initial begin
    for (int i = 0; i < gbc_pkg::KeyWords; i++) key_shadow[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_key();
    test_all_ones_key();
    test_key_schedule();
    test_random_blocks();

    drain_pipe();
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d blocks (%0d encrypt, %0d decrypt), %0d results checked,",
             encrypt_count + decrypt_count, encrypt_count, decrypt_count, result_count);
    $display("with %0d key word writes across directed and random keys.", key_writes);
    if (error_count == 0 && expected_blocks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
